FILE: design/nts_pkg.sv
// ---------------------------------------------------------------------------
// nts_pkg
// Shared types and constants for the nearest target search block: store
// geometry, field widths, opcodes, sequencer states and scan unit structs.
// ---------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

   // target store geometry
   localparam int MAX_TARGETS = 256;
   localparam int IDX_W       = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int COUNT_W     = $clog2(MAX_TARGETS + 1);

   // field widths
   localparam int COORD_W  = 16;
   localparam int ENTRY_W  = 2 * COORD_W;
   localparam int OFFSET_W = COORD_W + 1;
   localparam int DIST_W   = 20;
   localparam int SUM_W    = COORD_W + 1;
   localparam int OPCODE_W = 2;

   // distance reported when no target is in range
   localparam logic [DIST_W-1:0] NONE_DISTANCE = DIST_W'(999999);

   // radius after reset
   localparam logic [COORD_W-1:0] RADIUS_RESET = COORD_W'(16);

   // opcodes
   typedef logic [OPCODE_W-1:0] opcode_type;
   localparam opcode_type OP_CLEAR = 2'd0;
   localparam opcode_type OP_LOAD  = 2'd1;
   localparam opcode_type OP_QUERY = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // sequencer to scan unit
   typedef struct packed {
      logic init;
      logic data_valid;
   } scan_ctrl_type;

   // best match held by the scan unit
   typedef struct packed {
      logic                       found;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic [DIST_W-1:0]          distance;
   } scan_result_type;

endpackage

`default_nettype wire

FILE: design/nts_scan_unit.sv
// ---------------------------------------------------------------------------
// nts_scan_unit
// Shared distance unit: takes one stored target per cycle, checks it against
// the radius, forms its Manhattan distance and keeps the first strict best.
// ---------------------------------------------------------------------------
`default_nettype none

module nts_scan_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire nts_pkg::scan_ctrl_type        ctrl,
   input  wire logic [nts_pkg::ENTRY_W-1:0]   rd_data,
   input  wire logic [nts_pkg::COORD_W-1:0]   agent_x,
   input  wire logic [nts_pkg::COORD_W-1:0]   agent_y,
   input  wire logic [nts_pkg::COORD_W-1:0]   radius,
   output logic                               busy,
   output nts_pkg::scan_result_type           result
);

   logic [nts_pkg::COORD_W-1:0]  tx;
   logic [nts_pkg::COORD_W-1:0]  ty;
   logic [nts_pkg::OFFSET_W-1:0] diff_x;
   logic [nts_pkg::OFFSET_W-1:0] diff_y;
   logic [nts_pkg::OFFSET_W-1:0] neg_x;
   logic [nts_pkg::OFFSET_W-1:0] neg_y;
   logic [nts_pkg::COORD_W-1:0]  ax;
   logic [nts_pkg::COORD_W-1:0]  ay;

   logic                         s2_valid_ff;
   logic [nts_pkg::COORD_W-1:0]  s2_ax_ff;
   logic [nts_pkg::COORD_W-1:0]  s2_ay_ff;
   logic                         s2_in_range_ff;
   logic [nts_pkg::OFFSET_W-1:0] s2_off_x_ff;
   logic [nts_pkg::OFFSET_W-1:0] s2_off_y_ff;

   logic [nts_pkg::SUM_W-1:0]    sum;
   logic                         better;

   logic                         best_found_ff;
   logic [nts_pkg::OFFSET_W-1:0] best_off_x_ff;
   logic [nts_pkg::OFFSET_W-1:0] best_off_y_ff;
   logic [nts_pkg::DIST_W-1:0]   best_dist_ff;

   // offsets and absolute offsets of the target word
   always_comb begin
      tx     = rd_data[nts_pkg::COORD_W-1:0];
      ty     = rd_data[nts_pkg::ENTRY_W-1:nts_pkg::COORD_W];
      diff_x = {1'b0, tx} - {1'b0, agent_x};
      diff_y = {1'b0, ty} - {1'b0, agent_y};
      neg_x  = nts_pkg::OFFSET_W'(0) - diff_x;
      neg_y  = nts_pkg::OFFSET_W'(0) - diff_y;
      ax     = diff_x[nts_pkg::OFFSET_W-1] ? neg_x[nts_pkg::COORD_W-1:0]
                                           : diff_x[nts_pkg::COORD_W-1:0];
      ay     = diff_y[nts_pkg::OFFSET_W-1] ? neg_y[nts_pkg::COORD_W-1:0]
                                           : diff_y[nts_pkg::COORD_W-1:0];
   end

   // offset stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= ctrl.data_valid && !ctrl.init;
      end
      s2_ax_ff       <= ax;
      s2_ay_ff       <= ay;
      s2_in_range_ff <= (ax <= radius) && (ay <= radius);
      s2_off_x_ff    <= diff_x;
      s2_off_y_ff    <= diff_y;
   end

   // distance and strict compare against the best so far
   always_comb begin
      sum    = {1'b0, s2_ax_ff} + {1'b0, s2_ay_ff};
      better = s2_valid_ff && s2_in_range_ff &&
               (nts_pkg::DIST_W'(sum) < best_dist_ff);
   end

   // best match register
   always_ff @(posedge clock) begin
      if (reset || ctrl.init) begin
         best_found_ff <= 1'b0;
         best_off_x_ff <= '0;
         best_off_y_ff <= '0;
         best_dist_ff  <= nts_pkg::NONE_DISTANCE;
      end else if (better) begin
         best_found_ff <= 1'b1;
         best_off_x_ff <= s2_off_x_ff;
         best_off_y_ff <= s2_off_y_ff;
         best_dist_ff  <= nts_pkg::DIST_W'(sum);
      end
   end

   assign busy            = s2_valid_ff;
   assign result.found    = best_found_ff;
   assign result.offset_x = best_off_x_ff;
   assign result.offset_y = best_off_y_ff;
   assign result.distance = best_dist_ff;

   // no match means the empty answer
   a_none_values: assert property (@(posedge clock) disable iff (reset)
      !best_found_ff |-> (best_dist_ff == nts_pkg::NONE_DISTANCE) &&
                         (best_off_x_ff == '0) && (best_off_y_ff == '0))
      else $error("empty result not in its reset form");

   // a match appears only from a scanned word
   a_found_source: assert property (@(posedge clock) disable iff (reset)
      $rose(best_found_ff) |-> $past(s2_valid_ff))
      else $error("match set without a scanned word");

   // best distance never grows within a search
   a_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(ctrl.init)) |-> (best_dist_ff <= $past(best_dist_ff)))
      else $error("best distance grew during a search");

endmodule

`default_nettype wire

FILE: design/nearest_target_search.sv
// ---------------------------------------------------------------------------
// nearest_target_search
// Target store with a nearest-target query under the Manhattan metric.
// ---------------------------------------------------------------------------
// A request word carries an opcode and a position. Clear and load give no
// response; a load into a full store is dropped. A query walks the stored
// targets in load order through the single read port of the target memory,
// one entry per cycle. With N targets stored (up to 256), the query goes
// through the scan and drain states to the response state, or straight there
// with an empty store; no request is taken until the block returns to idle.
// The response word waits in an output register for rsp_ready; clears and
// loads go on meanwhile, and a later query holds its finished answer, with
// no request taken, until that register is free. Targets farther than the
// search radius on either axis are skipped; on equal distance the first
// loaded target wins. With no target in range, found is 0, distance is
// 999999 and both offsets are 0. The user must write the radius through the
// csr port only while the block is idle; the block does not enforce it. The
// radius is 16 after reset. The memory needs no clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_target_search (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [nts_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic [nts_pkg::COORD_W-1:0]          req_pos_x,
   input  wire logic [nts_pkg::COORD_W-1:0]          req_pos_y,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_found,
   output logic signed [nts_pkg::OFFSET_W-1:0]       rsp_offset_x,
   output logic signed [nts_pkg::OFFSET_W-1:0]       rsp_offset_y,
   output logic [nts_pkg::DIST_W-1:0]                rsp_distance,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [nts_pkg::COORD_W-1:0]          csr_search_radius
);

   nts_pkg::state_type             state_ff;
   nts_pkg::state_type             state_in;
   logic [nts_pkg::COUNT_W-1:0]    target_count_ff;
   logic [nts_pkg::COUNT_W-1:0]    target_count_in;
   logic [nts_pkg::IDX_W-1:0]      rd_addr_ff;
   logic [nts_pkg::IDX_W-1:0]      rd_addr_in;
   logic [nts_pkg::COORD_W-1:0]    radius_ff;
   logic [nts_pkg::COORD_W-1:0]    agent_x_ff;
   logic [nts_pkg::COORD_W-1:0]    agent_y_ff;
   logic [nts_pkg::ENTRY_W-1:0]    rd_data_ff;
   logic                           rd_valid_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_found_ff;
   logic [nts_pkg::OFFSET_W-1:0]   rsp_offset_x_ff;
   logic [nts_pkg::OFFSET_W-1:0]   rsp_offset_y_ff;
   logic [nts_pkg::DIST_W-1:0]     rsp_distance_ff;

   logic [nts_pkg::ENTRY_W-1:0]    target_mem [nts_pkg::MAX_TARGETS];

   logic                           req_accept;
   logic                           rd_en;
   logic                           wr_en;
   logic                           rsp_load;
   logic                           last_addr;
   logic                           scan_busy;
   nts_pkg::scan_ctrl_type         scan_ctrl;
   nts_pkg::scan_result_type       scan_result;

   assign req_accept = req_valid && req_ready;
   assign last_addr  = (nts_pkg::COUNT_W'(rd_addr_ff) + nts_pkg::COUNT_W'(1))
                       == target_count_ff;

   // sequencer next state and controls
   always_comb begin
      state_in             = state_ff;
      target_count_in      = target_count_ff;
      rd_addr_in           = rd_addr_ff;
      req_ready            = (state_ff == nts_pkg::ST_IDLE);
      rd_en                = 1'b0;
      wr_en                = 1'b0;
      rsp_load             = 1'b0;
      scan_ctrl.init       = 1'b0;
      scan_ctrl.data_valid = rd_valid_ff;
      case (state_ff)
         nts_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  nts_pkg::OP_CLEAR: begin
                     target_count_in = '0;
                  end
                  nts_pkg::OP_LOAD: begin
                     if (target_count_ff < nts_pkg::COUNT_W'(nts_pkg::MAX_TARGETS)) begin
                        wr_en           = 1'b1;
                        target_count_in = target_count_ff + nts_pkg::COUNT_W'(1);
                     end
                  end
                  nts_pkg::OP_QUERY: begin
                     scan_ctrl.init = 1'b1;
                     rd_addr_in     = '0;
                     state_in       = (target_count_ff == '0) ? nts_pkg::ST_RESP
                                                              : nts_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         nts_pkg::ST_SCAN: begin
            rd_en      = 1'b1;
            rd_addr_in = rd_addr_ff + nts_pkg::IDX_W'(1);
            if (last_addr) begin
               state_in = nts_pkg::ST_DRAIN;
            end
         end
         nts_pkg::ST_DRAIN: begin
            if (!rd_valid_ff && !scan_busy) begin
               state_in = nts_pkg::ST_RESP;
            end
         end
         nts_pkg::ST_RESP: begin
            // hand the answer over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = nts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nts_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= nts_pkg::ST_IDLE;
         target_count_ff <= '0;
         rd_addr_ff      <= '0;
         rd_valid_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         target_count_ff <= target_count_in;
         rd_addr_ff      <= rd_addr_in;
         rd_valid_ff     <= rd_en;
      end
   end

   // radius register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= nts_pkg::RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_search_radius;
      end
   end

   // agent position of the running query
   always_ff @(posedge clock) begin
      if (scan_ctrl.init) begin
         agent_x_ff <= req_pos_x;
         agent_y_ff <= req_pos_y;
      end
   end

   // target memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         target_mem[target_count_ff[nts_pkg::IDX_W-1:0]] <= {req_pos_y, req_pos_x};
      end
      if (rd_en) begin
         rd_data_ff <= target_mem[rd_addr_ff];
      end
   end

   nts_scan_unit u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (scan_ctrl),
      .rd_data (rd_data_ff),
      .agent_x (agent_x_ff),
      .agent_y (agent_y_ff),
      .radius  (radius_ff),
      .busy    (scan_busy),
      .result  (scan_result)
   );

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_found_ff    <= scan_result.found;
         rsp_offset_x_ff <= scan_result.offset_x;
         rsp_offset_y_ff <= scan_result.offset_y;
         rsp_distance_ff <= scan_result.distance;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_offset_x = rsp_offset_x_ff;
   assign rsp_offset_y = rsp_offset_y_ff;
   assign rsp_distance = rsp_distance_ff;

   // fill count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      target_count_ff <= nts_pkg::COUNT_W'(nts_pkg::MAX_TARGETS))
      else $error("target count beyond store size");

   // scan reads only filled entries
   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nts_pkg::ST_SCAN) |-> (nts_pkg::COUNT_W'(rd_addr_ff) < target_count_ff))
      else $error("scan address past fill count");

   // a query on a filled store starts a scan
   a_query_scan: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == nts_pkg::OP_QUERY) && (target_count_ff != '0))
      |=> (state_ff == nts_pkg::ST_SCAN))
      else $error("query did not start a scan");

   // response only once the scan pipeline is empty
   a_resp_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nts_pkg::ST_RESP) |-> (!rd_valid_ff && !scan_busy))
      else $error("response shown with scan still in flight");

endmodule

`default_nettype wire
